// ----- design/iirdf_pkg.sv -----
// ----------------------------------------------------------------------------
// IIR direct form I filter package
// Shared widths, input kind codes, controller states and the command and
// status groups that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package iirdf_pkg;

    localparam int MAX_TAPS   = 17;
    localparam int HIST_LEN   = MAX_TAPS - 1;
    localparam int KIND_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int IDX_W      = 5;
    localparam int COEF_W     = 32;
    localparam int TAP_W      = 5;
    localparam int HIST_IDX_W = 4;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int ACC_W      = PROD_W + 6;
    localparam int FRAC_BITS  = 24;
    localparam int QUOT_W     = ACC_W - FRAC_BITS;
    localparam int IN_DATA_W  = 56;

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NUM    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FB     = 2'd2;

    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic             mul_en;
        logic             sel_fb;
        logic [TAP_W-1:0] tap;
        logic             wr_num;
        logic             wr_fb;
        logic             finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ----- design/iir_direct_form_filter.sv -----
// ----------------------------------------------------------------------------
// IIR direct form I filter
// Streaming fixed-point IIR filter with loadable numerator and feedback taps.
//
//   Channel  Direction  Carries                          Handshake
//   s_axis   in         sample or coefficient write      tvalid / tready
//   m_axis   out        filtered sample and clip flag    tvalid / tready
//   cfg      in         taps in use                      valid / ready
//
// A sample holds the input until its result is loaded into the output
// register, after the products for all T taps in use have been summed,
// T being the taps in use; one multiplier and accumulator are
// shared by all products. A coefficient write is stored at its transfer.
// Reset is synchronous; it clears tables, histories and T is set to 9.
// A held result stalls the final load, and no new item is taken until it is done.
// ----------------------------------------------------------------------------
module iir_direct_form_filter
    import iirdf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // sample_in [15:0], coef_index [20:16], coef_value [52:21], zero [55:53]
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // kind [1:0]
    input  logic [KIND_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // filtered [15:0]
    output logic [SAMPLE_W-1:0]  m_axis_tdata,
    // clipped [0]
    output logic [0:0]           m_axis_tuser
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_clipped;

    iirdf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_coef_index (s_axis_tdata[SAMPLE_W +: IDX_W]),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    iirdf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_sample_in  (s_axis_tdata[SAMPLE_W-1:0]),
        .i_coef_index (s_axis_tdata[SAMPLE_W +: IDX_W]),
        .i_coef_value (s_axis_tdata[SAMPLE_W + IDX_W +: COEF_W]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_filtered   (m_axis_tdata),
        .o_clipped    (w_clipped)
    );

    assign m_axis_tuser = w_clipped;

endmodule

// ----- design/iirdf_ctrl.sv -----
// ----------------------------------------------------------------------------
// IIR filter controller
// Accepts input items, holds the tap count register and sequences the
// shared multiply-accumulate over the numerator and feedback taps.
// ----------------------------------------------------------------------------
module iirdf_ctrl
    import iirdf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [IDX_W-1:0]  i_coef_index,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_taps;
    logic [TAP_W-1:0] r_tap, n_tap;
    logic             r_fb, n_fb;
    logic [TAP_W-1:0] r_tlast, n_tlast;
    logic [TAP_W-1:0] w_tlast_clamped;
    logic             w_accept;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    // Last tap index in use, with the tap count held to the range 2 to MAX_TAPS.
    always_comb begin
        if (r_taps < IDX_W'(2)) begin
            w_tlast_clamped = TAP_W'(1);
        end else if (r_taps > IDX_W'(MAX_TAPS)) begin
            w_tlast_clamped = TAP_W'(MAX_TAPS - 1);
        end else begin
            w_tlast_clamped = TAP_W'(r_taps - IDX_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_taps  <= IDX_W'(9);
            r_tap   <= '0;
            r_fb    <= 1'b0;
            r_tlast <= TAP_W'(1);
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_fb    <= n_fb;
            r_tlast <= n_tlast;
            if (i_cfg_valid && o_cfg_ready) begin
                r_taps <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_tap      = r_tap;
        n_fb       = r_fb;
        n_tlast    = r_tlast;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.tap  = r_tap;
        o_cmd.sel_fb = r_fb;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    case (i_kind)
                        KIND_SAMPLE: begin
                            o_cmd.start = 1'b1;
                            n_tap       = '0;
                            n_fb        = 1'b0;
                            n_tlast     = w_tlast_clamped;
                            n_state     = ST_MAC;
                        end
                        KIND_NUM: o_cmd.wr_num = (i_coef_index < IDX_W'(MAX_TAPS));
                        KIND_FB:  o_cmd.wr_fb  = (i_coef_index < IDX_W'(MAX_TAPS));
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                // Order: b[0]*x, then b[m]*x[n-m] and a[m]*y[n-m] for each m.
                o_cmd.mul_en = 1'b1;
                if (!r_fb && r_tap == '0) begin
                    n_tap = TAP_W'(1);
                end else if (!r_fb) begin
                    n_fb = 1'b1;
                end else if (r_tap == r_tlast) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_fb  = 1'b0;
                    n_tap = r_tap + TAP_W'(1);
                end
            end
            ST_FLUSH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("result loaded while the output register is still full");

    a_sample_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && w_accept && i_kind == KIND_SAMPLE)
        |=> (r_state == ST_MAC && r_tap == '0 && !r_fb))
        else $error("sample transfer did not start the tap sequence at tap zero");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_en |-> (r_tap <= r_tlast && r_tlast != '0))
        else $error("tap index ran past the taps in use");

    a_last_product_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC && r_fb && r_tap == r_tlast) |=> r_state == ST_FLUSH)
        else $error("tap sequence did not end after the last feedback product");

endmodule

// ----- design/iirdf_dp.sv -----
// ----------------------------------------------------------------------------
// IIR filter datapath
// Coefficient tables, input and output history lines, the shared
// multiplier and accumulator, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module iirdf_dp
    import iirdf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic [IDX_W-1:0]           i_coef_index,
    input  logic signed [COEF_W-1:0]   i_coef_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_filtered,
    output logic                       o_clipped
);

    logic signed [COEF_W-1:0]   r_num [MAX_TAPS];
    logic signed [COEF_W-1:0]   r_fbk [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] r_xh  [HIST_LEN];
    logic signed [SAMPLE_W-1:0] r_yh  [HIST_LEN];
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_pvld;
    logic                       r_psub;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_ovalid;
    logic signed [SAMPLE_W-1:0] r_odata;
    logic                       r_oclip;

    logic [HIST_IDX_W-1:0]      w_hidx;
    logic signed [COEF_W-1:0]   w_coef_op;
    logic signed [SAMPLE_W-1:0] w_data_op;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [ACC_W-1:0]    w_rounded;
    logic signed [QUOT_W-1:0]   w_quot;
    logic                       w_fits;
    logic signed [SAMPLE_W-1:0] w_sat;

    assign w_hidx = HIST_IDX_W'(i_cmd.tap - TAP_W'(1));

    always_comb begin
        if (i_cmd.sel_fb) begin
            w_coef_op = r_fbk[i_cmd.tap];
            w_data_op = r_yh[w_hidx];
        end else begin
            w_coef_op = r_num[i_cmd.tap];
            w_data_op = (i_cmd.tap == '0) ? r_x : r_xh[w_hidx];
        end
    end

    assign n_prod = PROD_W'(w_coef_op) * PROD_W'(w_data_op);

    // Round half up, then floor by an arithmetic drop of the fraction bits.
    assign w_rounded = r_acc + ROUND_HALF;
    assign w_quot    = w_rounded[ACC_W-1:FRAC_BITS];
    assign w_fits    = (w_quot[QUOT_W-1:SAMPLE_W-1] == '0)
                    || (w_quot[QUOT_W-1:SAMPLE_W-1] == '1);

    always_comb begin
        if (w_fits) begin
            w_sat = w_quot[SAMPLE_W-1:0];
        end else if (w_quot[QUOT_W-1]) begin
            w_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_num[i] <= '0;
                r_fbk[i] <= '0;
            end
            for (int i = 0; i < HIST_LEN; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
        end else begin
            if (i_cmd.wr_num) begin
                r_num[i_coef_index] <= i_coef_value;
            end
            if (i_cmd.wr_fb) begin
                r_fbk[i_coef_index] <= i_coef_value;
            end
            if (i_cmd.finish) begin
                for (int i = HIST_LEN - 1; i > 0; i--) begin
                    r_xh[i] <= r_xh[i-1];
                    r_yh[i] <= r_yh[i-1];
                end
                r_xh[0] <= r_x;
                r_yh[0] <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pvld <= i_cmd.mul_en;
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_psub <= i_cmd.sel_fb;
        if (i_cmd.start) begin
            r_x   <= i_sample_in;
            r_acc <= '0;
        end else if (r_pvld) begin
            if (r_psub) begin
                r_acc <= r_acc - ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (i_cmd.finish) begin
            r_odata <= w_sat;
            r_oclip <= !w_fits;
        end
    end

    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_filtered     = r_odata;
    assign o_clipped      = r_oclip;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR direct form I filter testbench
// Streams sample and coefficient transfers into the filter and checks every
// filtered sample against a bit-accurate filter predictor kept in step with
// the accepted input. A short directed table covers the extremes, rounding
// ties, ignored writes and the unused kind. Random phases follow, each after
// a new tap count write, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import iirdf_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int IDLE_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 60;
    localparam int DIR_ROWS       = 24;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    idx;
        logic [COEF_W-1:0]   coef;
        logic                typed;
        logic [SAMPLE_W-1:0] want_y;
        logic                want_clip;
    } t_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic                clipped;
    } t_filt_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // sample_in [15:0], coef_index [20:16], coef_value [52:21], zero [55:53]
    logic [IN_DATA_W-1:0] s_axis_tdata;
    // kind [1:0]
    logic [KIND_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // filtered [15:0]
    logic [SAMPLE_W-1:0]  m_axis_tdata;
    // clipped [0]
    logic [0:0]           m_axis_tuser;

    // Filter state mirrored by the predictor.
    logic signed [SAMPLE_W-1:0] x_hist [HIST_LEN];
    logic signed [SAMPLE_W-1:0] y_hist [HIST_LEN];
    logic signed [COEF_W-1:0]   num_tbl [MAX_TAPS];
    logic signed [COEF_W-1:0]   fb_tbl [MAX_TAPS];
    logic [IDX_W-1:0]           taps_cfg;

    t_filt_result expected_out [$];
    t_item        dir_table [DIR_ROWS];
    int           err_count = 0;
    int           idle_cycles = 0;

    iir_direct_form_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 60);
    endfunction

    function automatic int eff_taps(input logic [IDX_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > MAX_TAPS)
            return MAX_TAPS;
        return int'(v);
    endfunction

    function automatic t_item row(input logic [KIND_W-1:0] kind,
                                  input logic [SAMPLE_W-1:0] sample,
                                  input logic [IDX_W-1:0] idx,
                                  input logic [COEF_W-1:0] coef);
        t_item it;
        it = '0;
        it.kind   = kind;
        it.sample = sample;
        it.idx    = idx;
        it.coef   = coef;
        return it;
    endfunction

    function automatic t_item row_y(input logic [SAMPLE_W-1:0] sample,
                                    input logic [SAMPLE_W-1:0] y,
                                    input logic clip);
        t_item it;
        it = row(KIND_SAMPLE, sample, '0, '0);
        it.typed     = 1'b1;
        it.want_y    = y;
        it.want_clip = clip;
        return it;
    endfunction

    // Signed random value of roughly +/- 2^span.
    function automatic logic [COEF_W-1:0] rand_coef(input int span);
        logic signed [COEF_W-1:0] r;
        r = $urandom;
        return r >>> (31 - span);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        else if (p < 25)
            return SAMPLE_W'($urandom_range(0, 63) - 32);
        else
            return SAMPLE_W'($urandom);
    endfunction

    // Applies one accepted item to the filter state and works out its result.
    task automatic predict_item(input t_item it, output bit produced,
                                output t_filt_result res);
        longint acc;
        longint r;
        int     t;
        produced = 1'b0;
        res      = '0;
        if (it.kind == KIND_NUM || it.kind == KIND_FB) begin
            if (it.idx < MAX_TAPS) begin
                if (it.kind == KIND_NUM)
                    num_tbl[it.idx] = it.coef;
                else
                    fb_tbl[it.idx] = it.coef;
            end
        end else if (it.kind == KIND_SAMPLE) begin
            t   = eff_taps(taps_cfg);
            acc = longint'(num_tbl[0]) * longint'($signed(it.sample));
            for (int m = 1; m < t; m++) begin
                acc += longint'(num_tbl[m]) * longint'(x_hist[m-1]);
                acc -= longint'(fb_tbl[m]) * longint'(y_hist[m-1]);
            end
            // Round half up, then floor by the Q.24 scale.
            r = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            res.clipped = 1'b0;
            if (r > 32767) begin
                r = 32767;
                res.clipped = 1'b1;
            end
            if (r < -32768) begin
                r = -32768;
                res.clipped = 1'b1;
            end
            res.filtered = r[SAMPLE_W-1:0];
            for (int i = HIST_LEN - 1; i > 0; i--) begin
                x_hist[i] = x_hist[i-1];
                y_hist[i] = y_hist[i-1];
            end
            x_hist[0] = it.sample;
            y_hist[0] = res.filtered;
            produced  = 1'b1;
        end
    endtask

    // Called right after a rising edge; returns at the edge of the transfer.
    task automatic transfer_item(input t_item it);
        int unsigned  gap;
        bit           produced;
        t_filt_result res;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.coef, it.idx, it.sample};
        s_axis_tuser  <= it.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(it, produced, res);
        if (produced) begin
            if (it.typed) begin
                res.filtered = it.want_y;
                res.clipped  = it.want_clip;
            end
            expected_out.insert(expected_out.size(), res);
        end
    endtask

    task automatic settle(input int tail);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_out.size() != 0);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_taps(input logic [IDX_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        taps_cfg = v;
    endtask

    // Ready toggles in runs; occasional long runs give stall-free stretches.
    initial begin : drive_ready
        int unsigned stall;
        forever begin
            stall = pick_gap();
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(100, 300)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_filt_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_out.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                want = expected_out.pop_front();
                if (m_axis_tdata !== want.filtered)
                    report_mismatch($sformatf("filtered %h, expected %h",
                                              m_axis_tdata, want.filtered));
                if (m_axis_tuser[0] !== want.clipped)
                    report_mismatch($sformatf("clipped %b, expected %b",
                                              m_axis_tuser[0], want.clipped));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_item          it;
        int             n;
        int             t;
        logic [IDX_W-1:0] taps_val;
        int unsigned    p;
        int             phase_taps [NUM_PHASES];

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_SAMPLE;

        for (int i = 0; i < HIST_LEN; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
        for (int i = 0; i < MAX_TAPS; i++) begin
            num_tbl[i] = '0;
            fb_tbl[i]  = '0;
        end
        taps_cfg = 5'd9;

        // Tables are clear after reset, so the first outputs are zero.
        dir_table[0]  = row_y(16'h7FFF, 16'h0000, 1'b0);
        dir_table[1]  = row_y(16'h8000, 16'h0000, 1'b0);
        dir_table[2]  = row(KIND_NUM, '0, 5'd0, 32'h7FFF_FFFF);
        dir_table[3]  = row_y(16'h7FFF, 16'h7FFF, 1'b1);
        dir_table[4]  = row_y(16'h8000, 16'h8000, 1'b1);
        dir_table[5]  = row(KIND_NUM, '0, 5'd0, 32'h8000_0000);
        dir_table[6]  = row_y(16'h8000, 16'h7FFF, 1'b1);
        // A half-gain tap exposes the rounding of ties toward plus infinity.
        dir_table[7]  = row(KIND_NUM, '0, 5'd0, 32'h0080_0000);
        dir_table[8]  = row_y(16'h0001, 16'h0001, 1'b0);
        dir_table[9]  = row_y(16'hFFFF, 16'h0000, 1'b0);
        dir_table[10] = row_y(16'hFFFD, 16'hFFFF, 1'b0);
        // Out-of-range indexes, the unused kind and the leading feedback tap
        // must all leave the response unchanged.
        dir_table[11] = row(KIND_NUM, '0, 5'd17, 32'h7FFF_FFFF);
        dir_table[12] = row(KIND_FB, '0, 5'd31, 32'h7FFF_FFFF);
        dir_table[13] = row(KIND_UNUSED, 16'hFFFF, 5'd0, 32'h7FFF_FFFF);
        dir_table[14] = row(KIND_FB, '0, 5'd0, 32'h7FFF_FFFF);
        dir_table[15] = row_y(16'h0003, 16'h0002, 1'b0);
        dir_table[16] = row(KIND_NUM, '0, 5'd16, 32'h0100_0000);
        dir_table[17] = row(KIND_FB, '0, 5'd1, 32'h00C0_0000);
        dir_table[18] = row(KIND_NUM, '0, 5'd1, 32'hFF00_0000);
        dir_table[19] = row(KIND_SAMPLE, 16'd1000, '0, '0);
        dir_table[20] = row(KIND_SAMPLE, 16'hB1E0, '0, '0);
        dir_table[21] = row(KIND_SAMPLE, 16'h7FFF, '0, '0);
        dir_table[22] = row(KIND_FB, '0, 5'd16, 32'hFFFF_FFFF);
        dir_table[23] = row(KIND_SAMPLE, 16'h0000, '0, '0);

        // Both clamped extremes and both legal extremes of the tap count.
        phase_taps = '{17, 2, 0, 31, 1, 5, 16, 3, 9};
        phase_taps[NUM_PHASES-1] = $urandom_range(2, 17);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            transfer_item(dir_table[r]);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle(IDLE_CYCLES);
            taps_val = IDX_W'(phase_taps[ph]);
            write_taps(taps_val);
            t = eff_taps(taps_val);

            // Load a fresh coefficient set for the taps in use.
            for (int m = 0; m < t; m++) begin
                p = $urandom_range(0, 9);
                transfer_item(row(KIND_NUM, '0, IDX_W'(m),
                                  rand_coef(p < 7 ? 22 : (p < 9 ? 25 : 31))));
                if (m != 0)
                    transfer_item(row(KIND_FB, '0, IDX_W'(m),
                                      rand_coef(p < 7 ? 20 : (p < 9 ? 24 : 31))));
            end

            n = 0;
            while (n < PHASE_ITEMS) begin
                if (n == PHASE_ITEMS / 2 && (ph == 3 || $urandom_range(0, 2) == 0))
                    settle(0);
                p = $urandom_range(0, 99);
                if (p < 65) begin
                    it = row(KIND_SAMPLE, rand_sample(), '0, '0);
                    n++;
                end else if (p < 80) begin
                    it = row(KIND_NUM, '0, IDX_W'($urandom_range(0, MAX_TAPS - 1)),
                             rand_coef($urandom_range(0, 3) == 0 ? 31 : 22));
                    n++;
                end else if (p < 93) begin
                    it = row(KIND_FB, '0, IDX_W'($urandom_range(0, MAX_TAPS - 1)),
                             rand_coef($urandom_range(0, 3) == 0 ? 31 : 20));
                    n++;
                end else if (p < 97) begin
                    it = row($urandom_range(0, 1) != 0 ? KIND_NUM : KIND_FB,
                             SAMPLE_W'($urandom),
                             IDX_W'($urandom_range(MAX_TAPS, 31)), COEF_W'($urandom));
                end else begin
                    it = row(KIND_UNUSED, SAMPLE_W'($urandom),
                             IDX_W'($urandom), COEF_W'($urandom));
                end
                transfer_item(it);
            end
        end

        settle(IDLE_CYCLES);
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
